// ===== src/mpsm_pkg.sv =====
// shared constants, codes and types of the multi-pattern string matcher
// no dependencies; imported by every other file of the block
`default_nettype none
package mpsm_pkg;

  localparam int MAX_STATES    = 512;
  localparam int ALPHABET_SIZE = 26;
  localparam int MAX_WORDS     = 16;
  localparam int POS_W         = 32;
  localparam int STATE_W       = $clog2(MAX_STATES);
  localparam int CNT_W         = STATE_W + 1;
  localparam int SYM_W         = 5;
  localparam int CMD_W         = 3;
  localparam int KIND_W        = 3;
  localparam int WORD_W        = $clog2(MAX_WORDS);
  localparam int WCNT_W        = WORD_W + 1;
  localparam int LEN_W         = STATE_W;
  localparam int GT_DEPTH      = MAX_STATES * ALPHABET_SIZE;
  localparam int GT_AW         = $clog2(GT_DEPTH);

  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PATTERN = 3'd1;
  localparam logic [CMD_W-1:0] CMD_EOW     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BUILD   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TEXT    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RESTART = 3'd5;

  typedef enum logic [KIND_W-1:0] {
    KIND_MATCH      = 3'd0,
    KIND_BUILD_DONE = 3'd1,
    KIND_FULL       = 3'd2,
    KIND_TOO_MANY   = 3'd3,
    KIND_EMPTY      = 3'd4,
    KIND_WRONG      = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    OP_CLEAR   = 3'd0,
    OP_PATTERN = 3'd1,
    OP_EOW     = 3'd2,
    OP_BUILD   = 3'd3,
    OP_TEXT    = 3'd4,
    OP_RESTART = 3'd5
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SYM_W-1:0] sym;
    logic             sym_ok;
  } item_t;

endpackage
`default_nettype wire

// ===== src/mpsm_front.sv =====
// front end: accepts input transactions, decodes the command and queues them
// depends on mpsm_pkg
`default_nettype none
module mpsm_front
  import mpsm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [CMD_W-1:0] command,
  input  wire logic [SYM_W-1:0] symbol,
  output logic                  item_valid,
  input  wire logic             item_ready,
  output item_t                 item
);

  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      dec;
  logic       known;
  logic       push;
  logic       pop;

  always_comb begin
    dec.sym    = symbol;
    dec.sym_ok = (symbol < SYM_W'(ALPHABET_SIZE));
    dec.op     = OP_CLEAR;
    known      = 1'b1;
    unique case (command)
      CMD_CLEAR:   dec.op = OP_CLEAR;
      CMD_PATTERN: dec.op = OP_PATTERN;
      CMD_EOW:     dec.op = OP_EOW;
      CMD_BUILD:   dec.op = OP_BUILD;
      CMD_TEXT:    dec.op = OP_TEXT;
      CMD_RESTART: dec.op = OP_RESTART;
      default:     known = 1'b0;
    endcase
  end

  assign in_ready   = (count != 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = entries[rd_ptr];
  // unused commands are taken and dropped here
  assign push       = in_valid && in_ready && known;
  assign pop        = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= dec;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== src/mpsm_back.sv =====
// back end: trie load, failure link build, text scan and the result register
// depends on mpsm_pkg; holds the goto, node, failure, mask and bfs memories
`default_nettype none
module mpsm_back
  import mpsm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire item_t             item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [KIND_W-1:0]      kind,
  output logic [WORD_W-1:0]      word_index,
  output logic [31:0]            start_pos,
  output logic [31:0]            end_pos,
  output logic [CNT_W-1:0]       states_used,
  output logic                   last
);

  typedef enum logic [22:0] {
    S_IDLE      = 23'b1 << 0,
    S_EMIT      = 23'b1 << 1,
    S_LK_A      = 23'b1 << 2,
    S_LK_B      = 23'b1 << 3,
    S_LK_C      = 23'b1 << 4,
    S_LK_F      = 23'b1 << 5,
    S_PAT_FIN   = 23'b1 << 6,
    S_EOW_RD    = 23'b1 << 7,
    S_EOW_WR    = 23'b1 << 8,
    S_ROOT_FIN  = 23'b1 << 9,
    S_BFS_POP   = 23'b1 << 10,
    S_BFS_Q     = 23'b1 << 11,
    S_BFS_F     = 23'b1 << 12,
    S_CHILD_FIN = 23'b1 << 13,
    S_NEXTC     = 23'b1 << 14,
    S_FWALK_FIN = 23'b1 << 15,
    S_MG1       = 23'b1 << 16,
    S_MG2       = 23'b1 << 17,
    S_BDONE     = 23'b1 << 18,
    S_TEXT_FIN  = 23'b1 << 19,
    S_TX_M      = 23'b1 << 20,
    S_TX_E      = 23'b1 << 21,
    S_CLEAR     = 23'b1 << 22
  } state_t;

  typedef enum logic [2:0] {
    R_PAT, R_ROOT, R_CHILD, R_FWALK, R_TEXT
  } ret_t;

  // memories
  logic [STATE_W-1:0]       gt_mem   [GT_DEPTH];
  logic [STATE_W+SYM_W-1:0] info_mem [MAX_STATES];
  logic [STATE_W-1:0]       fail_mem [MAX_STATES];
  logic [MAX_WORDS-1:0]     mask_mem [MAX_STATES];
  logic [STATE_W-1:0]       bfsq_mem [MAX_STATES];
  logic [LEN_W-1:0]         wlen     [MAX_WORDS];

  logic [STATE_W-1:0]       gt_q;
  logic [STATE_W+SYM_W-1:0] info_q;
  logic [STATE_W-1:0]       fail_q;
  logic [MAX_WORDS-1:0]     mask_q;
  logic [STATE_W-1:0]       bfsq_q;

  logic [GT_AW-1:0]     ga;
  logic                 gt_we;
  logic [GT_AW-1:0]     gt_wa;
  logic [STATE_W-1:0]   gt_wd;
  logic [GT_AW-1:0]     clr_addr;
  logic [STATE_W-1:0]   info_ra;
  logic                 info_we;
  logic [STATE_W-1:0]   fail_ra;
  logic [STATE_W-1:0]   fail_wa;
  logic [STATE_W-1:0]   fail_wd;
  logic                 fail_we;
  logic [STATE_W-1:0]   mask_ra;
  logic [STATE_W-1:0]   mask_wa;
  logic [MAX_WORDS-1:0] mask_wd;
  logic                 mask_we;
  logic                 bfsq_we;

  state_t               state;
  ret_t                 ret;
  logic [STATE_W-1:0]   ws;
  logic [SYM_W-1:0]     wc;
  logic                 walk;
  logic                 lk_real;
  logic [STATE_W-1:0]   lk_res;
  logic [CNT_W-1:0]     alloc;
  logic [WCNT_W-1:0]    words;
  logic [STATE_W-1:0]   load_node;
  logic [LEN_W-1:0]     load_len;
  logic [STATE_W-1:0]   scan_node;
  logic [POS_W-1:0]     pos;
  logic [POS_W-1:0]     cur_pos;
  logic                 built;
  logic                 fault;
  logic [CNT_W-1:0]     head;
  logic [CNT_W-1:0]     tail;
  logic [STATE_W-1:0]   bs;
  logic [STATE_W-1:0]   bfail;
  logic [STATE_W-1:0]   child;
  logic [STATE_W-1:0]   bf;
  logic [MAX_WORDS-1:0] mcq;
  logic [MAX_WORDS-1:0] tmask;
  kind_t                pend_kind;
  logic [CNT_W-1:0]     pend_used;

  logic                 real_hit;
  logic                 ofree;
  logic [WORD_W-1:0]    low_w;
  logic [MAX_WORDS-1:0] tmask_rest;
  logic                 last_sym;

  assign ga       = GT_AW'(ws) * GT_AW'(ALPHABET_SIZE) + GT_AW'(wc);
  // an entry is live only if its child was allocated for this exact parent and symbol
  assign real_hit = (gt_q != '0) && (CNT_W'(gt_q) < alloc) && (info_q == {ws, wc});
  assign ofree    = !out_valid || out_ready;
  assign item_ready = (state == S_IDLE);
  assign last_sym = (wc == SYM_W'(ALPHABET_SIZE - 1));

  always_comb begin
    low_w = '0;
    for (int i = MAX_WORDS - 1; i >= 0; i--) begin
      if (tmask[i]) low_w = WORD_W'(i);
    end
    tmask_rest = tmask & ~(MAX_WORDS'(1) << low_w);
  end

  // memory port control
  always_comb begin
    gt_we   = 1'b0;
    gt_wa   = ga;
    gt_wd   = alloc[STATE_W-1:0];
    info_we = 1'b0;
    info_ra = gt_q;
    fail_ra = ws;
    fail_we = 1'b0;
    fail_wa = child;
    fail_wd = lk_res;
    mask_ra = load_node;
    mask_we = 1'b0;
    mask_wa = child;
    mask_wd = '0;
    bfsq_we = 1'b0;
    case (state)
      // goto table zeroed once after reset so every read is defined
      S_CLEAR: begin
        gt_we = 1'b1;
        gt_wa = clr_addr;
        gt_wd = '0;
      end
      S_PAT_FIN: begin
        if (!lk_real && alloc != CNT_W'(MAX_STATES)) begin
          gt_we   = 1'b1;
          info_we = 1'b1;
          mask_we = 1'b1;
          mask_wa = alloc[STATE_W-1:0];
          mask_wd = '0;
        end
      end
      S_EOW_WR: begin
        mask_we = 1'b1;
        mask_wa = load_node;
        mask_wd = mask_q | (MAX_WORDS'(1) << words[WORD_W-1:0]);
      end
      S_ROOT_FIN: begin
        fail_we = lk_real;
        fail_wa = lk_res;
        fail_wd = '0;
        bfsq_we = lk_real;
      end
      S_BFS_Q: fail_ra = bfsq_q;
      S_FWALK_FIN: begin
        fail_we = 1'b1;
        bfsq_we = 1'b1;
        mask_ra = child;
      end
      S_MG1: mask_ra = bf;
      S_MG2: begin
        mask_we = 1'b1;
        mask_wd = mcq | ((bf == '0) ? '0 : mask_q);
      end
      S_TEXT_FIN: mask_ra = lk_res;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (gt_we) gt_mem[gt_wa] <= gt_wd;
    gt_q <= gt_mem[ga];
  end

  always_ff @(posedge clk) begin
    if (info_we) info_mem[alloc[STATE_W-1:0]] <= {ws, wc};
    info_q <= info_mem[info_ra];
  end

  always_ff @(posedge clk) begin
    if (fail_we) fail_mem[fail_wa] <= fail_wd;
    fail_q <= fail_mem[fail_ra];
  end

  always_ff @(posedge clk) begin
    if (mask_we) mask_mem[mask_wa] <= mask_wd;
    mask_q <= mask_mem[mask_ra];
  end

  always_ff @(posedge clk) begin
    if (bfsq_we) bfsq_mem[tail[STATE_W-1:0]] <= (state == S_ROOT_FIN) ? lk_res : child;
    bfsq_q <= bfsq_mem[head[STATE_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      alloc     <= CNT_W'(1);
      words     <= '0;
      load_node <= '0;
      load_len  <= '0;
      scan_node <= '0;
      pos       <= '0;
      built     <= 1'b0;
      fault     <= 1'b0;
    end else begin
      // emitting states load the result register themselves
      if (out_valid && out_ready && state != S_EMIT && state != S_TX_E) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + GT_AW'(1);
          if (clr_addr == GT_AW'(GT_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (item_valid) begin
            pend_used <= '0;
            ws        <= load_node;
            wc        <= item.sym;
            walk      <= 1'b0;
            unique case (item.op)
              OP_CLEAR: begin
                alloc     <= CNT_W'(1);
                words     <= '0;
                load_node <= '0;
                load_len  <= '0;
                scan_node <= '0;
                pos       <= '0;
                built     <= 1'b0;
                fault     <= 1'b0;
              end
              OP_RESTART: begin
                scan_node <= '0;
                pos       <= '0;
              end
              OP_PATTERN: begin
                if (built) begin
                  pend_kind <= KIND_WRONG;
                  state     <= S_EMIT;
                end else if (item.sym_ok && !fault) begin
                  ret   <= R_PAT;
                  state <= S_LK_A;
                end
              end
              OP_EOW: begin
                if (built) begin
                  pend_kind <= KIND_WRONG;
                  state     <= S_EMIT;
                end else if (!fault && load_len != '0 && words < WCNT_W'(MAX_WORDS)) begin
                  state <= S_EOW_RD;
                end else begin
                  if (!fault) begin
                    pend_kind <= (load_len == '0) ? KIND_EMPTY : KIND_TOO_MANY;
                    state     <= S_EMIT;
                  end
                  fault     <= 1'b0;
                  load_node <= '0;
                  load_len  <= '0;
                end
              end
              OP_BUILD: begin
                if (built || load_len != '0 || fault) begin
                  pend_kind <= KIND_WRONG;
                  state     <= S_EMIT;
                end else begin
                  ws    <= '0;
                  wc    <= '0;
                  tail  <= '0;
                  head  <= '0;
                  ret   <= R_ROOT;
                  state <= S_LK_A;
                end
              end
              OP_TEXT: begin
                if (!built) begin
                  pend_kind <= KIND_WRONG;
                  state     <= S_EMIT;
                end else begin
                  cur_pos <= pos;
                  pos     <= pos + POS_W'(1);
                  if (!item.sym_ok) begin
                    scan_node <= '0;
                  end else begin
                    ws    <= scan_node;
                    walk  <= 1'b1;
                    ret   <= R_TEXT;
                    state <= S_LK_A;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_EMIT: begin
          if (ofree) begin
            out_valid   <= 1'b1;
            kind        <= pend_kind;
            word_index  <= '0;
            start_pos   <= '0;
            end_pos     <= '0;
            states_used <= pend_used;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_LK_A: state <= S_LK_B;
        S_LK_B: state <= S_LK_C;
        S_LK_C: begin
          lk_real <= real_hit;
          lk_res  <= real_hit ? gt_q : '0;
          if (walk && !real_hit && ws != '0) begin
            state <= S_LK_F;
          end else begin
            unique case (ret)
              R_PAT:   state <= S_PAT_FIN;
              R_ROOT:  state <= S_ROOT_FIN;
              R_CHILD: state <= S_CHILD_FIN;
              R_FWALK: state <= S_FWALK_FIN;
              R_TEXT:  state <= S_TEXT_FIN;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_LK_F: begin
          ws    <= fail_q;
          state <= S_LK_A;
        end
        S_PAT_FIN: begin
          state <= S_IDLE;
          if (lk_real) begin
            load_node <= lk_res;
            load_len  <= load_len + LEN_W'(1);
          end else if (alloc == CNT_W'(MAX_STATES)) begin
            fault     <= 1'b1;
            pend_kind <= KIND_FULL;
            state     <= S_EMIT;
          end else begin
            load_node <= alloc[STATE_W-1:0];
            alloc     <= alloc + CNT_W'(1);
            load_len  <= load_len + LEN_W'(1);
          end
        end
        S_EOW_RD: state <= S_EOW_WR;
        S_EOW_WR: begin
          wlen[words[WORD_W-1:0]] <= load_len;
          words     <= words + WCNT_W'(1);
          load_node <= '0;
          load_len  <= '0;
          state     <= S_IDLE;
        end
        S_ROOT_FIN: begin
          if (lk_real) tail <= tail + CNT_W'(1);
          if (last_sym) begin
            state <= S_BFS_POP;
          end else begin
            wc    <= wc + SYM_W'(1);
            state <= S_LK_A;
          end
        end
        S_BFS_POP: begin
          state <= (head == tail) ? S_BDONE : S_BFS_Q;
        end
        S_BFS_Q: begin
          bs    <= bfsq_q;
          head  <= head + CNT_W'(1);
          state <= S_BFS_F;
        end
        S_BFS_F: begin
          bfail <= fail_q;
          ws    <= bs;
          wc    <= '0;
          walk  <= 1'b0;
          ret   <= R_CHILD;
          state <= S_LK_A;
        end
        S_CHILD_FIN: begin
          if (lk_real) begin
            child <= lk_res;
            ws    <= bfail;
            walk  <= 1'b1;
            ret   <= R_FWALK;
            state <= S_LK_A;
          end else begin
            state <= S_NEXTC;
          end
        end
        S_NEXTC: begin
          if (last_sym) begin
            state <= S_BFS_POP;
          end else begin
            wc    <= wc + SYM_W'(1);
            ws    <= bs;
            walk  <= 1'b0;
            ret   <= R_CHILD;
            state <= S_LK_A;
          end
        end
        S_FWALK_FIN: begin
          bf    <= lk_res;
          tail  <= tail + CNT_W'(1);
          state <= S_MG1;
        end
        S_MG1: begin
          mcq   <= mask_q;
          state <= S_MG2;
        end
        S_MG2: state <= S_NEXTC;
        S_BDONE: begin
          built     <= 1'b1;
          pend_kind <= KIND_BUILD_DONE;
          pend_used <= alloc;
          state     <= S_EMIT;
        end
        S_TEXT_FIN: begin
          scan_node <= lk_res;
          // the root never carries a word
          state     <= (lk_res == '0) ? S_IDLE : S_TX_M;
        end
        S_TX_M: begin
          tmask <= mask_q;
          state <= (mask_q == '0) ? S_IDLE : S_TX_E;
        end
        S_TX_E: begin
          if (ofree) begin
            out_valid   <= 1'b1;
            kind        <= KIND_MATCH;
            word_index  <= low_w;
            start_pos   <= 32'(cur_pos - POS_W'(wlen[low_w]) + POS_W'(1));
            end_pos     <= 32'(cur_pos);
            states_used <= '0;
            last        <= (tmask_rest == '0);
            tmask       <= tmask_rest;
            if (tmask_rest == '0) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/multi_pattern_string_matcher.sv =====
// a text symbol takes a goto lookup, one more per failure hop, and one result
// per match (no lookup outside the alphabet, no result off the root)
// build: a lookup per root symbol, then per queued state one per symbol, with a
// failure walk and mask merge per edge; one item at a time behind a 2-entry queue
// sync reset, then a pass zeroes the goto table before the first item
// top level of the matcher; depends on mpsm_pkg, mpsm_front and mpsm_back
`default_nettype none
module multi_pattern_string_matcher
  import mpsm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CMD_W-1:0]  command,
  input  wire logic [SYM_W-1:0]  symbol,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [KIND_W-1:0]      kind,
  output logic [WORD_W-1:0]      word_index,
  output logic [31:0]            start_pos,
  output logic [31:0]            end_pos,
  output logic [CNT_W-1:0]       states_used,
  output logic                   last
);

  logic  item_valid;
  logic  item_ready;
  item_t item;

  mpsm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .symbol     (symbol),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  mpsm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .word_index  (word_index),
    .start_pos   (start_pos),
    .end_pos     (end_pos),
    .states_used (states_used),
    .last        (last)
  );

endmodule
`default_nettype wire

// ===== src/mpsm_checker.sv =====
// port-level checks of the matcher result channel, bound to the top level
// depends on mpsm_pkg and multi_pattern_string_matcher
`default_nettype none
module mpsm_checker
  import mpsm_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [KIND_W-1:0] kind,
  input wire logic [WORD_W-1:0] word_index,
  input wire logic [31:0]       start_pos,
  input wire logic [31:0]       end_pos,
  input wire logic [CNT_W-1:0]  states_used,
  input wire logic              last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(end_pos))
    else $error("result changed while stalled");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_MATCH |-> last)
    else $error("non-match transaction not marked last");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_MATCH |->
      word_index == '0 && start_pos == '0 && end_pos == '0)
    else $error("match fields set on non-match transaction");

  a_used: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_BUILD_DONE |-> states_used == '0)
    else $error("state count outside build done");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind multi_pattern_string_matcher mpsm_checker u_mpsm_checker (.*);
`default_nettype wire

// ===== bench/tb_multi_pattern_string_matcher.sv =====
// self-checking testbench of the multi-pattern string matcher: directed and random tests
// compare every result against a predictor of the trie, failure links and scan
// depends on mpsm_pkg and multi_pattern_string_matcher
`default_nettype none
module tb_multi_pattern_string_matcher;
  import mpsm_pkg::*;

  localparam int IDLE_LIMIT = 300000;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] word;
    logic [31:0]       spos;
    logic [31:0]       epos;
    logic [CNT_W-1:0]  used;
    logic              fin;
  } match_rec_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [CMD_W-1:0]  command;
  logic [SYM_W-1:0]  symbol;
  logic              out_valid;
  logic              out_ready;
  logic [KIND_W-1:0] kind;
  logic [WORD_W-1:0] word_index;
  logic [31:0]       start_pos;
  logic [31:0]       end_pos;
  logic [CNT_W-1:0]  states_used;
  logic              last;

  multi_pattern_string_matcher i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .command(command), .symbol(symbol),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
    .word_index(word_index), .start_pos(start_pos), .end_pos(end_pos),
    .states_used(states_used), .last(last)
  );

  // predicted automaton
  bit                 edge_ok[GT_DEPTH];
  int unsigned        edge_to[GT_DEPTH];
  int unsigned        fail_to[MAX_STATES];
  bit [MAX_WORDS-1:0] word_mask[MAX_STATES];
  int unsigned        word_len[MAX_WORDS];
  int unsigned        n_states, n_words, load_at, load_len, scan_at;
  bit [31:0]          text_pos;
  bit                 is_built, in_fault;

  match_rec_t expected_q[$];
  int errors = 0;
  int burst_left = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  task automatic clear_automaton();
    foreach (edge_ok[i]) edge_ok[i] = 0;
    foreach (word_mask[i]) word_mask[i] = '0;
    n_states = 1; n_words = 0; load_at = 0; load_len = 0; scan_at = 0;
    text_pos = 0; is_built = 0; in_fault = 0;
  endtask

  task automatic push_result(logic [KIND_W-1:0] k, int unsigned w, logic [31:0] sp,
                             logic [31:0] ep, int unsigned u, bit f);
    match_rec_t r;
    r.kind = k; r.word = WORD_W'(w); r.spos = sp; r.epos = ep; r.used = CNT_W'(u);
    r.fin = f;
    expected_q.push_back(r);
  endtask

  // follow failure links from s until symbol c has an edge
  function automatic int unsigned next_state(int unsigned s, int unsigned c);
    int unsigned guard = 0;
    while (!edge_ok[s*ALPHABET_SIZE+c] && guard < MAX_STATES) begin
      s = fail_to[s];
      guard++;
    end
    if (!edge_ok[s*ALPHABET_SIZE+c]) s = 0;
    return edge_to[s*ALPHABET_SIZE+c];
  endfunction

  task automatic build_links();
    int unsigned pend[$];
    int unsigned s, child, f;
    for (int c = 0; c < ALPHABET_SIZE; c++) begin
      if (!edge_ok[c]) begin
        edge_ok[c] = 1;
        edge_to[c] = 0;
      end else if (edge_to[c] != 0) begin
        fail_to[edge_to[c]] = 0;
        pend.push_back(edge_to[c]);
      end
    end
    while (pend.size() > 0) begin
      s = pend.pop_front();
      for (int c = 0; c < ALPHABET_SIZE; c++) begin
        if (edge_ok[s*ALPHABET_SIZE+c]) begin
          child = edge_to[s*ALPHABET_SIZE+c];
          f = next_state(fail_to[s], c);
          fail_to[child] = f;
          word_mask[child] |= word_mask[f];
          pend.push_back(child);
        end
      end
    end
    is_built = 1;
  endtask

  task automatic predict(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym);
    int unsigned idx, total, n;
    bit [31:0] pos;
    case (cmd)
      CMD_CLEAR: clear_automaton();
      CMD_PATTERN: begin
        if (is_built) push_result(KIND_WRONG, 0, 0, 0, 0, 1);
        else if (sym < ALPHABET_SIZE && !in_fault) begin
          idx = load_at*ALPHABET_SIZE + sym;
          if (!edge_ok[idx] && n_states >= MAX_STATES) begin
            in_fault = 1;
            push_result(KIND_FULL, 0, 0, 0, 0, 1);
          end else begin
            if (!edge_ok[idx]) begin
              edge_ok[idx] = 1;
              edge_to[idx] = n_states;
              n_states++;
            end
            load_at = edge_to[idx];
            load_len++;
          end
        end
      end
      CMD_EOW: begin
        if (is_built) push_result(KIND_WRONG, 0, 0, 0, 0, 1);
        else begin
          if (in_fault) ;
          else if (load_len == 0) push_result(KIND_EMPTY, 0, 0, 0, 0, 1);
          else if (n_words >= MAX_WORDS) push_result(KIND_TOO_MANY, 0, 0, 0, 0, 1);
          else begin
            word_mask[load_at][n_words] = 1'b1;
            word_len[n_words] = load_len;
            n_words++;
          end
          in_fault = 0; load_at = 0; load_len = 0;
        end
      end
      CMD_BUILD: begin
        if (is_built || load_len != 0 || in_fault) push_result(KIND_WRONG, 0, 0, 0, 0, 1);
        else begin
          build_links();
          push_result(KIND_BUILD_DONE, 0, 0, 0, n_states, 1);
        end
      end
      CMD_TEXT: begin
        if (!is_built) push_result(KIND_WRONG, 0, 0, 0, 0, 1);
        else begin
          pos = text_pos;
          text_pos = text_pos + 1;
          if (sym >= ALPHABET_SIZE) scan_at = 0;
          else begin
            scan_at = next_state(scan_at, sym);
            total = $countones(word_mask[scan_at]);
            n = 0;
            for (int w = 0; w < MAX_WORDS; w++) begin
              if (word_mask[scan_at][w]) begin
                n++;
                push_result(KIND_MATCH, w, 32'(pos - word_len[w] + 1), pos, 0, n == total);
              end
            end
          end
        end
      end
      CMD_RESTART: begin
        scan_at = 0;
        text_pos = 0;
      end
      default: ;
    endcase
  endtask

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(99) < 40) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    command  <= cmd;
    symbol   <= sym;
    do @(posedge clk); while (!in_ready);
    predict(cmd, sym);
  endtask

  task automatic load_word(string w);
    for (int i = 0; i < w.len(); i++) send_item(CMD_PATTERN, SYM_W'(w[i] - 8'd97));
    send_item(CMD_EOW, 0);
  endtask

  task automatic scan_text(string t);
    for (int i = 0; i < t.len(); i++) send_item(CMD_TEXT, SYM_W'(t[i] - 8'd97));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic test_order_and_matching();
    send_item(CMD_CLEAR, 0);
    send_item(CMD_TEXT, 0);        // text before build
    send_item(CMD_EOW, 0);         // empty word
    send_item(CMD_PATTERN, 31);    // outside the alphabet
    load_word("he");
    load_word("she");
    load_word("his");
    send_item(CMD_PATTERN, 7);
    send_item(CMD_BUILD, 0);       // word partly loaded
    send_item(CMD_PATTERN, 4);
    send_item(CMD_PATTERN, 17);
    send_item(CMD_PATTERN, 18);
    send_item(CMD_EOW, 0);
    send_item(CMD_BUILD, 0);
    send_item(CMD_BUILD, 0);       // already built
    send_item(CMD_PATTERN, 25);
    send_item(CMD_EOW, 0);
    scan_text("ushers");
    send_item(CMD_TEXT, 30);       // out of alphabet resets the scan
    scan_text("hers");
    send_item(CMD_RESTART, 0);
    send_item(3'd6, 0);
    send_item(3'd7, 31);
    scan_text("she");
    drain();
  endtask

  task automatic test_word_limit();
    send_item(CMD_CLEAR, 0);
    send_item(CMD_BUILD, 0);       // root only
    scan_text("ab");
    send_item(CMD_CLEAR, 0);
    for (int i = 0; i <= MAX_WORDS; i++) begin
      send_item(CMD_PATTERN, SYM_W'(i));
      send_item(CMD_EOW, 0);
    end
    send_item(CMD_BUILD, 0);
    scan_text("apqz");
    drain();
  endtask

  task automatic test_table_full();
    send_item(CMD_CLEAR, 0);
    for (int i = 0; i < MAX_STATES + 2; i++) begin
      send_item(CMD_PATTERN, SYM_W'(i % ALPHABET_SIZE));
    end
    send_item(CMD_BUILD, 0);       // faulted word still open
    send_item(CMD_EOW, 0);         // dropped silently
    load_word("ab");
    load_word("z");
    load_word("abcd");
    send_item(CMD_BUILD, 0);
    scan_text("abcdab");
    drain();
  endtask

  task automatic test_output_backpressure();
    send_item(CMD_CLEAR, 0);
    load_word("a");
    load_word("aa");
    load_word("aaa");
    load_word("ba");
    send_item(CMD_BUILD, 0);
    drain();
    hold_left = 400;
    for (int i = 0; i < 40; i++) send_item(CMD_TEXT, (i % 7 == 6) ? 5'd1 : 5'd0);
    drain();
  endtask

  task automatic test_random(int items);
    int sent = 0;
    int alpha, nw, len;
    while (sent < items) begin
      send_item(CMD_CLEAR, 0);
      alpha = ($urandom_range(9) == 0) ? ALPHABET_SIZE : $urandom_range(2, 4);
      nw = $urandom_range(1, 7);
      for (int w = 0; w < nw; w++) begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          send_item(CMD_PATTERN, SYM_W'($urandom_range(alpha - 1)));
        end
        send_item(CMD_EOW, 0);
        sent += len + 1;
      end
      send_item(CMD_BUILD, 0);
      for (int i = 0; i < $urandom_range(15, 40); i++) begin
        if ($urandom_range(99) < 8) send_item(CMD_W'($urandom_range(7)), SYM_W'($urandom()));
        else if ($urandom_range(99) < 3) send_item(CMD_TEXT, SYM_W'($urandom_range(26, 31)));
        else send_item(CMD_TEXT, SYM_W'($urandom_range(alpha - 1)));
        sent++;
      end
      sent += 2;
    end
    drain();
  endtask

  // receiver: own stall pattern plus long hold-offs on request
  initial begin
    int stall_pct = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        if ($urandom_range(63) == 0) stall_pct = $urandom_range(2) * 35;
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // check each result transaction against the oldest expectation
  always @(posedge clk) begin
    match_rec_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) report("unexpected result kind", 32'(kind), 0);
      else begin
        e = expected_q.pop_front();
        if (kind != e.kind) report("kind", 32'(kind), 32'(e.kind));
        if (word_index != e.word) report("word_index", 32'(word_index), 32'(e.word));
        if (start_pos != e.spos) report("start_pos", start_pos, e.spos);
        if (end_pos != e.epos) report("end_pos", end_pos, e.epos);
        if (states_used != e.used) report("states_used", 32'(states_used), 32'(e.used));
        if (last != e.fin) report("last", 32'(last), 32'(e.fin));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_CLEAR;
    symbol = '0;
    clear_automaton();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_order_and_matching();
    test_word_limit();
    test_table_full();
    test_output_backpressure();
    test_random(260);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
